// File: rtl/cge_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cge_pkg
// Shared types and constants of the colour grid byte symbol encoder.
// ----------------------------------------------------------------------------
package cge_pkg;

    localparam int FRAME_DIGITS = 7;
    localparam int COUNT_BITS   = 3 * FRAME_DIGITS;
    localparam int HDR_LEN      = FRAME_DIGITS + 1;
    localparam int SYM_CELLS    = 3;
    localparam int CHK_CELLS    = 6;
    localparam int MAX_RESULTS  = SYM_CELLS + CHK_CELLS + HDR_LEN;
    localparam int STEP_W       = $clog2(MAX_RESULTS);
    localparam int HDR_W        = $clog2(HDR_LEN);

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [4:0] ROW_ORIGIN = 5'd1;
    localparam logic [4:0] COL_ORIGIN = 5'd8;

    localparam logic [2:0] COLOR_RED  = 3'd1;
    localparam logic [2:0] COLOR_BLUE = 3'd4;

    typedef enum logic [1:0] {
        JOB_BEGIN,
        JOB_DATA,
        JOB_END
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [4:0]             row;
        logic [4:0]             col;
        logic [2:0]             sym_hi;
        logic [2:0]             sym_mid;
        logic [2:0]             sym_lo;
        logic                   full;
        logic [5:0]             sum_lo;
        logic [5:0]             sum_mid;
        logic [5:0]             sum_hi;
        logic [COUNT_BITS-1:0]  frame;
    } job_t;

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
        logic [2:0] color;
        logic       done;
        logic       last;
    } cell_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } queue_status_t;

endpackage : cge_pkg
`default_nettype wire

// File: rtl/color_grid_byte_symbol_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// color_grid_byte_symbol_encoder_top
// Byte stream to colour grid cell encoder.
//
// Input stream: tuser carries the command (begin, data, end), tdata the byte.
// Output stream: one transaction per painted cell; tdata packs row, column
// and colour, tuser flags the final checksum cell of a frame and tlast
// marks the final cell caused by one input command.
// The first cell of a command is written into the job queue and then into
// the output register. The sequencer sends one cell per cycle while the
// receiver is ready; a data byte paints 3 cells (17 when it fills a frame),
// begin 11, end 9. An unused command code is accepted and produces nothing.
// A two-job queue parts the command front from the cell sequencer, so new
// commands are taken while cells are still being sent.
// Reset: cursor to row 1 column 8, sums and frame number to zero, queue and
// output empty. When the receiver stalls, the output cell holds, the queue
// fills and tready drops at the input.
// ----------------------------------------------------------------------------
module color_grid_byte_symbol_encoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [4:0] cell_row, [9:5] cell_col,
                                             // [12:10] cell_color
    output logic             m_axis_tuser,   // [0] frame_complete
    output logic             m_axis_tlast    // last_cell
);
    import cge_pkg::*;

    queue_status_t q_status;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head;

    cge_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    cge_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    cge_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule : color_grid_byte_symbol_encoder_top
`default_nettype wire

// File: rtl/cge_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cge_front
// Accepts commands, keeps cursor, sums and frame number, and issues jobs.
// ----------------------------------------------------------------------------
module cge_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]            s_axis_tuser,   // [1:0] opcode
    input  wire cge_pkg::queue_status_t q_status,
    output logic                       push,
    output cge_pkg::job_t              push_job
);
    import cge_pkg::*;

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
        logic       full;
    } walk_t;

    logic [4:0]            row_reg, row_next;
    logic [4:0]            col_reg, col_next;
    logic [5:0]            sum_lo_reg, sum_lo_next;
    logic [5:0]            sum_mid_reg, sum_mid_next;
    logic [5:0]            sum_hi_reg, sum_hi_next;
    logic [COUNT_BITS-1:0] frame_reg, frame_next;

    logic                  accept;
    logic [2:0]            hi, mid, lo;
    logic [5:0]            add_lo, add_mid, add_hi;
    logic [COUNT_BITS-1:0] frame_inc;
    walk_t                 walk;

    function automatic walk_t advance(input logic [4:0] r, input logic [4:0] col);
        walk_t      w;
        logic [5:0] c;
        w.row  = r;
        w.col  = col;
        w.full = 1'b0;
        c      = {1'b0, col} + 6'd3;
        if (r >= 5'd1 && r <= 5'd7) begin
            if (c >= 6'd17) begin
                w.row = r + 5'd1;
                w.col = (r == 5'd7) ? 5'd1 : 5'd8;
            end else begin
                w.col = c[4:0];
            end
        end else if (r >= 5'd8 && r <= 5'd16) begin
            if (c == 6'd7 || c == 6'd17) begin
                w.col = c[4:0] + 5'd1;
            end else if (c >= 6'd24) begin
                w.row = r + 5'd1;
                w.col = (r == 5'd16) ? 5'd8 : 5'd1;
            end else begin
                w.col = c[4:0];
            end
        end else if (r >= 5'd17 && r <= 5'd23) begin
            if (c == 6'd17) begin
                c = 6'd18;
            end
            if (c >= 6'd24) begin
                if (r == 5'd23) begin
                    w.full = 1'b1;
                end else begin
                    w.row = r + 5'd1;
                    w.col = 5'd8;
                end
            end else begin
                w.col = c[4:0];
            end
        end else begin
            w.row = ROW_ORIGIN;
            w.col = COL_ORIGIN;
        end
        return w;
    endfunction

    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign hi        = s_axis_tdata[7:5];
    assign mid       = s_axis_tdata[4:2];
    assign lo        = {s_axis_tdata[1:0], ^s_axis_tdata};
    assign add_lo    = sum_lo_reg + {3'b0, lo};
    assign add_mid   = sum_mid_reg + {3'b0, mid};
    assign add_hi    = sum_hi_reg + {3'b0, hi};
    assign frame_inc = frame_reg + COUNT_BITS'(1);
    assign walk      = advance(row_reg, col_reg);

    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        sum_lo_next  = sum_lo_reg;
        sum_mid_next = sum_mid_reg;
        sum_hi_next  = sum_hi_reg;
        frame_next   = frame_reg;
        push         = 1'b0;

        push_job.kind    = JOB_DATA;
        push_job.row     = row_reg;
        push_job.col     = col_reg;
        push_job.sym_hi  = hi;
        push_job.sym_mid = mid;
        push_job.sym_lo  = lo;
        push_job.full    = 1'b0;
        push_job.sum_lo  = sum_lo_reg;
        push_job.sum_mid = sum_mid_reg;
        push_job.sum_hi  = sum_hi_reg;
        push_job.frame   = frame_reg;

        if (accept)
        begin
            unique case (s_axis_tuser)
                OP_BEGIN:
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_BEGIN;
                end
                OP_DATA:
                begin
                    push             = 1'b1;
                    push_job.kind    = JOB_DATA;
                    push_job.sum_lo  = add_lo;
                    push_job.sum_mid = add_mid;
                    push_job.sum_hi  = add_hi;
                    push_job.full    = walk.full;
                    if (walk.full)
                    begin
                        sum_lo_next    = '0;
                        sum_mid_next   = '0;
                        sum_hi_next    = '0;
                        frame_next     = frame_inc;
                        push_job.frame = frame_inc;
                        row_next       = ROW_ORIGIN;
                        col_next       = COL_ORIGIN;
                    end
                    else
                    begin
                        sum_lo_next  = add_lo;
                        sum_mid_next = add_mid;
                        sum_hi_next  = add_hi;
                        row_next     = walk.row;
                        col_next     = walk.col;
                    end
                end
                OP_END:
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_END;
                    sum_lo_next   = '0;
                    sum_mid_next  = '0;
                    sum_hi_next   = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= ROW_ORIGIN;
            col_reg     <= COL_ORIGIN;
            sum_lo_reg  <= '0;
            sum_mid_reg <= '0;
            sum_hi_reg  <= '0;
            frame_reg   <= '0;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            sum_lo_reg  <= sum_lo_next;
            sum_mid_reg <= sum_mid_next;
            sum_hi_reg  <= sum_hi_next;
            frame_reg   <= frame_next;
        end
    end

endmodule : cge_front
`default_nettype wire

// File: rtl/cge_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cge_queue
// Two-entry job queue between the front and the cell sequencer.
// ----------------------------------------------------------------------------
module cge_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire cge_pkg::job_t          push_job,
    input  wire logic                   pop,
    output cge_pkg::job_t               head,
    output cge_pkg::queue_status_t      status
);
    import cge_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head              = mem[rd_ptr_reg];
    assign status.head_valid = (count_reg != 2'd0);
    assign status.full       = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : cge_queue
`default_nettype wire

// File: rtl/cge_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cge_back
// Walks through the cells of the job at the queue head into the output
// register, one cell a cycle while the output is empty or being taken.
// ----------------------------------------------------------------------------
module cge_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cge_pkg::job_t          head,
    input  wire cge_pkg::queue_status_t q_status,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // [4:0] cell_row, [9:5] cell_col,
                                                       // [12:10] cell_color
    output logic                        m_axis_tuser,  // [0] frame_complete
    output logic                        m_axis_tlast   // last_cell
);
    import cge_pkg::*;

    localparam int CHK_BASE = SYM_CELLS;
    localparam int HDR_BASE = SYM_CELLS + CHK_CELLS;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    cell_t             out_reg, out_next;
    cell_t             cur_cell;
    logic              load;
    logic [STEP_W-1:0] chk_idx, hdr_idx_data, start_idx;

    function automatic cell_t chk_cell(input logic [2:0] m, input job_t j);
        cell_t c;
        c.col  = 5'd17;
        c.done = 1'b0;
        c.last = 1'b0;
        unique case (m)
            3'd0:    begin c.row = 5'd17; c.color = j.sum_lo[2:0];  end
            3'd1:    begin c.row = 5'd16; c.color = j.sum_lo[5:3];  end
            3'd2:    begin c.row = 5'd19; c.color = j.sum_mid[2:0]; end
            3'd3:    begin c.row = 5'd18; c.color = j.sum_mid[5:3]; end
            3'd4:    begin c.row = 5'd21; c.color = j.sum_hi[2:0];  end
            default: begin c.row = 5'd20; c.color = j.sum_hi[5:3]; c.done = 1'b1; end
        endcase
        return c;
    endfunction

    function automatic cell_t hdr_cell(input logic [HDR_W-1:0] h, input job_t j);
        cell_t      c;
        logic [2:0] digit;
        digit  = '0;
        c.done = 1'b0;
        c.last = 1'b0;
        for (int d = 0; d < FRAME_DIGITS; d++)
        begin
            if (h == HDR_W'(d))
            begin
                digit = j.frame[3*d +: 3];
            end
        end
        if (h == HDR_W'(FRAME_DIGITS))
        begin
            if (j.frame[0])
            begin
                c.row   = 5'd15;
                c.color = COLOR_BLUE;
            end
            else
            begin
                c.row   = 5'd9;
                c.color = COLOR_RED;
            end
            c.col = 5'd17;
        end
        else
        begin
            c.row   = 5'd15 - 5'(h);
            c.col   = 5'd7;
            c.color = 3'd7 - digit;
        end
        return c;
    endfunction

    assign chk_idx      = step_reg - STEP_W'(CHK_BASE);
    assign hdr_idx_data = step_reg - STEP_W'(HDR_BASE);
    assign start_idx    = step_reg - STEP_W'(HDR_LEN);

    always_comb
    begin
        cur_cell = '0;
        unique case (head.kind)
            JOB_DATA:
            begin
                if (step_reg < STEP_W'(SYM_CELLS))
                begin
                    cur_cell.row  = head.row;
                    cur_cell.col  = head.col + 5'(step_reg);
                    cur_cell.done = 1'b0;
                    priority case (step_reg)
                        STEP_W'(0): cur_cell.color = head.sym_hi;
                        STEP_W'(1): cur_cell.color = head.sym_mid;
                        default:    cur_cell.color = head.sym_lo;
                    endcase
                end
                else if (step_reg < STEP_W'(HDR_BASE))
                begin
                    cur_cell = chk_cell(chk_idx[2:0], head);
                end
                else
                begin
                    cur_cell = hdr_cell(hdr_idx_data[HDR_W-1:0], head);
                end
                cur_cell.last = head.full ? (step_reg == STEP_W'(MAX_RESULTS - 1))
                                          : (step_reg == STEP_W'(SYM_CELLS - 1));
            end
            JOB_BEGIN:
            begin
                if (step_reg < STEP_W'(HDR_LEN))
                begin
                    cur_cell = hdr_cell(step_reg[HDR_W-1:0], head);
                end
                else
                begin
                    cur_cell.row   = 5'd11 + 5'(start_idx);
                    cur_cell.col   = 5'd17;
                    cur_cell.color = COLOR_RED;
                    cur_cell.done  = 1'b0;
                end
                cur_cell.last = (step_reg == STEP_W'(HDR_LEN + SYM_CELLS - 1));
            end
            default:
            begin
                if (step_reg < STEP_W'(SYM_CELLS))
                begin
                    cur_cell.row   = 5'd11 + 5'(step_reg);
                    cur_cell.col   = 5'd17;
                    cur_cell.color = COLOR_BLUE;
                    cur_cell.done  = 1'b0;
                end
                else
                begin
                    cur_cell = chk_cell(chk_idx[2:0], head);
                end
                cur_cell.last = (step_reg == STEP_W'(SYM_CELLS + CHK_CELLS - 1));
            end
        endcase
    end

    always_comb
    begin
        load           = q_status.head_valid && (!out_valid_reg || m_axis_tready);
        pop            = load && cur_cell.last;
        out_next       = load ? cur_cell : out_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && !m_axis_tready);
        if (load)
        begin
            step_next = cur_cell.last ? '0 : step_reg + STEP_W'(1);
        end
        else
        begin
            step_next = step_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b0, out_reg.color, out_reg.col, out_reg.row};
    assign m_axis_tuser  = out_reg.done;
    assign m_axis_tlast  = out_reg.last;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < STEP_W'(MAX_RESULTS))
        else $error("cell step beyond longest job");

    a_step_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0 |-> q_status.head_valid)
        else $error("job left the queue before its last cell");

    a_done_place: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.done |-> out_reg.row == 5'd20 && out_reg.col == 5'd17)
        else $error("frame completion flagged off the last checksum cell");

    a_pop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && out_reg.last && step_reg == '0)
        else $error("job retired without a last cell");

endmodule : cge_back
`default_nettype wire
